>>> design/positional_array_table_core_defines.svh
`ifndef POSITIONAL_ARRAY_TABLE_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define PAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pat check failed");

// next-cycle implication
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pat check failed");

`endif

>>> design/pat_pkg.sv
package pat_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_UPDATE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   localparam int unsigned POS_W   = 7;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned DATA_W  = 32;

   typedef struct packed {
      kind_type                   kind;
      logic [POS_W-1:0]           position;
      logic signed [DATA_W-1:0]   value;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic [INDEX_W-1:0]         found_index;
      logic [COUNT_W-1:0]         count;
   } rsp_word_type;

endpackage

>>> design/pat_ram.sv
module pat_ram
   import pat_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pat_seq.sv
module pat_seq
   import pat_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6,
   parameter int unsigned CW    = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_word_type      req_word,
   output logic              busy,
   output logic              res_valid,
   output rsp_word_type      res_word,
   input  logic              res_take,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [DATA_W-1:0] rd_data,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [DATA_W-1:0] wr_data
);

   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
   localparam int unsigned IW = (AW > INDEX_W) ? AW : INDEX_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INS  = 5'b00010,
      S_DEL  = 5'b00100,
      S_SRCH = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     tag_ff, tag_in;
   rsp_word_type      res_ff, res_in;

   logic [PW-1:0]     pos_ext;
   logic [PW-1:0]     cnt_ext;
   logic [CW-1:0]     ptr_inc;
   logic [CW-1:0]     ptr_dec;
   logic [CW-1:0]     cnt_inc;
   logic [CW-1:0]     cnt_dec;
   logic              full;

   function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
      logic [PW-1:0] e;
      e = PW'(c);
      return e[COUNT_W-1:0];
   endfunction

   function automatic logic [INDEX_W-1:0] to_index(input logic [AW-1:0] a);
      logic [IW-1:0] e;
      e = IW'(a);
      return e[INDEX_W-1:0];
   endfunction

   assign pos_ext = PW'(req_word.position);
   assign cnt_ext = PW'(cnt_ff);
   assign ptr_inc = ptr_ff + 1'b1;
   assign ptr_dec = ptr_ff - 1'b1;
   assign cnt_inc = cnt_ff + 1'b1;
   assign cnt_dec = cnt_ff - 1'b1;
   assign full    = (cnt_ff == CW'(DEPTH));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      pend_in  = 1'b0;
      tag_in   = tag_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = tag_ff;
      wr_data  = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in             = req_word.value;
               pos_in             = pos_ext[CW-1:0];
               res_in.status      = ST_OK;
               res_in.found_index = '0;
               res_in.count       = to_count(cnt_ff);
               case (req_word.kind)
                  KIND_INSERT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                        state_in      = S_DONE;
                     end else if (pos_ext > cnt_ext) begin
                        res_in.status = ST_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        ptr_in   = cnt_ff;
                        state_in = S_INS;
                     end
                  end
                  KIND_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        res_in.status = ST_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        ptr_in   = pos_ext[CW-1:0] + 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  KIND_SEARCH: begin
                     ptr_in   = '0;
                     state_in = S_SRCH;
                  end
                  default: begin
                     if (pos_ext >= cnt_ext) begin
                        res_in.status = ST_BADPOS;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ext[AW-1:0];
                        wr_data = req_word.value;
                     end
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INS: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (ptr_ff > pos_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_dec[AW-1:0];
               pend_in = 1'b1;
               tag_in  = ptr_ff[AW-1:0];
               ptr_in  = ptr_dec;
            end else if (!pend_ff) begin
               wr_en        = 1'b1;
               wr_addr      = pos_ff[AW-1:0];
               wr_data      = key_ff;
               cnt_in       = cnt_inc;
               res_in.count = to_count(cnt_inc);
               state_in     = S_DONE;
            end
         end
         S_DEL: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (ptr_ff < cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               tag_in  = ptr_dec[AW-1:0];
               ptr_in  = ptr_inc;
            end else if (!pend_ff) begin
               cnt_in       = cnt_dec;
               res_in.count = to_count(cnt_dec);
               state_in     = S_DONE;
            end
         end
         S_SRCH: begin
            if (pend_ff && (rd_data == key_ff)) begin
               res_in.status      = ST_OK;
               res_in.found_index = to_index(tag_ff);
               state_in           = S_DONE;
            end else if (ptr_ff < cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               tag_in  = ptr_ff[AW-1:0];
               ptr_in  = ptr_inc;
            end else if (!pend_ff) begin
               res_in.status = ST_NOTFOUND;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      key_ff <= key_in;
      tag_ff <= tag_in;
      res_ff <= res_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_word  = res_ff;

endmodule

>>> design/positional_array_table_core.sv
// channel | direction | handshake            | word
// req     | in        | req_valid, req_stall | req_word (kind, position, value)
// rsp     | out       | rsp_valid, rsp_stall | rsp_word (status, found_index, count)
//
// One command at a time; every table read goes through the single RAM read port.
// Insert and delete shift the entries between position and the fill count one at a time;
// search scans from index 0 to a match or the fill count; update and refused commands move nothing.
// Reset is synchronous and clears the fill count; the table contents are not cleared.
// A stalled rsp word holds in the output register while the next command runs.
module positional_array_table_core
   import pat_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic              busy;
   logic              res_valid;
   rsp_word_type      res_word;
   logic              res_take;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   pat_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pat_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .busy      (busy),
      .res_valid (res_valid),
      .res_word  (res_word),
      .res_take  (res_take),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> design/pat_checker.sv
`include "positional_array_table_core_defines.svh"

module pat_checker
   import pat_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   `PAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `PAT_ASSERT_NOW(a_idx_zero, clock, reset, rsp_valid && (rsp_word.status != ST_OK), rsp_word.found_index == '0)
   `PAT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `PAT_ASSERT_NEXT(a_no_early_rsp, clock, reset, !rsp_valid && req_valid && !req_stall, !rsp_valid)

endmodule

bind positional_array_table_core pat_checker u_pat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
